>>> rtl/core/pbg_pkg.sv
// ----------------------------------------------------------------------------
// pbg_pkg: shared types and constants for the Philox block generator
// Word, block and key types, round multipliers, Weyl key increments and
// configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package pbg_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned BLOCK_WORDS  = 4;
  localparam int unsigned BLOCK_W      = WORD_W * BLOCK_WORDS;
  localparam int unsigned ROUND_COUNT_DEF = 10;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef logic [WORD_W-1:0] pbg_word_t;
  typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] pbg_block_t;

  typedef struct packed {
    pbg_word_t k1;
    pbg_word_t k0;
  } pbg_key_t;

  localparam pbg_word_t MUL_A          = 32'hD251_1F53;
  localparam pbg_word_t MUL_B          = 32'hCD9E_8D57;
  localparam pbg_word_t WEYL_A         = 32'h9E37_79B9;
  localparam pbg_word_t WEYL_B         = 32'hBB67_AE85;
  localparam pbg_word_t KEY_LOW_RESET  = 32'h0000_0000;
  localparam pbg_word_t KEY_HIGH_RESET = 32'hFEED_C0DE;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } pbg_reg_e;

endpackage : pbg_pkg

`default_nettype wire

>>> rtl/core/pbg_cfg_regs.sv
// ----------------------------------------------------------------------------
// pbg_cfg_regs: APB key registers
// Holds the two key words; zero-wait writes and combinational reads.
// ----------------------------------------------------------------------------
`default_nettype none

module pbg_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pbg_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [pbg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [pbg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output pbg_pkg::pbg_key_t                     key_o
);
  import pbg_pkg::*;

  pbg_key_t key_q, key_d;
  pbg_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = pbg_reg_e'(paddr[2]);

  always_comb begin
    key_d  = key_q;
    prdata = '0;
    unique case (reg_sel)
      REG_KEY_LOW: begin
        prdata = key_q.k0;
        if (wr_en) key_d.k0 = pwdata;
      end
      REG_KEY_HIGH: begin
        prdata = key_q.k1;
        if (wr_en) key_d.k1 = pwdata;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q.k0 <= KEY_LOW_RESET;
      key_q.k1 <= KEY_HIGH_RESET;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule : pbg_cfg_regs

`default_nettype wire

>>> rtl/core/pbg_round_cell.sv
// ----------------------------------------------------------------------------
// pbg_round_cell: one Philox round with its pipeline register
// Two 32x32 products, high/low mix with neighbor words and the round key,
// then the key advances by the Weyl increments for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module pbg_round_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire pbg_pkg::pbg_block_t blk_i,
  input  wire pbg_pkg::pbg_key_t   key_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output pbg_pkg::pbg_block_t      blk_o,
  output pbg_pkg::pbg_key_t        key_o
);
  import pbg_pkg::*;

  logic [2*WORD_W-1:0] prod_a, prod_b;
  pbg_block_t blk_d, blk_q;
  pbg_key_t   key_d, key_q;
  logic       valid_q, load;

  assign prod_a = {{WORD_W{1'b0}}, blk_i[0]} * {{WORD_W{1'b0}}, MUL_A};
  assign prod_b = {{WORD_W{1'b0}}, blk_i[2]} * {{WORD_W{1'b0}}, MUL_B};

  always_comb begin
    blk_d[0] = prod_b[2*WORD_W-1:WORD_W] ^ blk_i[1] ^ key_i.k0;
    blk_d[1] = prod_b[WORD_W-1:0];
    blk_d[2] = prod_a[2*WORD_W-1:WORD_W] ^ blk_i[3] ^ key_i.k1;
    blk_d[3] = prod_a[WORD_W-1:0];
    key_d.k0 = key_i.k0 + WEYL_A;
    key_d.k1 = key_i.k1 + WEYL_B;
  end

  // take a new request when empty or when the neighbor drains us
  assign ready_o = !valid_q || ready_i;
  assign load    = ready_o && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      blk_q <= blk_d;
      key_q <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;
  assign key_o   = key_q;

endmodule : pbg_round_cell

`default_nettype wire

>>> rtl/core/philox_block_generator_core.sv
// ----------------------------------------------------------------------------
// philox_block_generator_core: Philox4x32 counter-based random block engine
// A row of round cells turns each 128-bit counter into four random words.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one request per 128-bit counter. tdata = {count_word3,
//   count_word2, count_word1, count_word0}, word0 in bits 31:0.
//   m_axis: one block per request, same order. tdata = {rand_word3 ..
//   rand_word0}, word0 in bits 31:0.
//   APB: key_low at 0x0, key_high at 0x4 (register picked by paddr[2]).
//   Keys are sampled as a request enters the first cell; write them only
//   while the pipeline is empty.
// Throughput
//   One request per cycle sustained while m_axis_tready stays high; a
//   request passes through every cell register in turn. Each cell does
//   one round: two 32x32 multipliers and the xor mix, followed by its
//   register; the last cell is the output register.
// Reset
//   All cells empty, key_low = 0, key_high = 0xFEEDC0DE.
// Back-pressure
//   A stalled output holds its block. Upstream cells keep filling any empty
//   slots, so s_axis_tready only drops once every cell holds a request.
// ----------------------------------------------------------------------------
`default_nettype none

module philox_block_generator_core #(
  parameter int unsigned ROUND_COUNT = pbg_pkg::ROUND_COUNT_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // counter requests
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // fields from bit 0: count_word0, count_word1, count_word2, count_word3
  input  wire logic [pbg_pkg::BLOCK_W-1:0]      s_axis_tdata,
  // random blocks
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // fields from bit 0: rand_word0, rand_word1, rand_word2, rand_word3
  output logic      [pbg_pkg::BLOCK_W-1:0]      m_axis_tdata,
  // configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pbg_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [pbg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [pbg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready
);
  import pbg_pkg::*;

  pbg_key_t key_cfg;

  // chain nets: index i feeds cell i, index i+1 comes out of it
  logic       chain_valid [ROUND_COUNT+1];
  logic       chain_ready [ROUND_COUNT+1];
  pbg_block_t chain_blk   [ROUND_COUNT+1];
  pbg_key_t   chain_key   [ROUND_COUNT+1];
  logic [ROUND_COUNT-1:0] stage_valid;

  pbg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_o   (key_cfg)
  );

  assign chain_valid[0] = s_axis_tvalid;
  assign chain_blk[0]   = pbg_block_t'(s_axis_tdata);
  assign chain_key[0]   = key_cfg;
  assign s_axis_tready  = chain_ready[0];

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    pbg_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[g]),
      .ready_o (chain_ready[g]),
      .blk_i   (chain_blk[g]),
      .key_i   (chain_key[g]),
      .valid_o (chain_valid[g+1]),
      .ready_i (chain_ready[g+1]),
      .blk_o   (chain_blk[g+1]),
      .key_o   (chain_key[g+1])
    );
    assign stage_valid[g] = chain_valid[g+1];
  end

  // the key advanced past the last round is not needed
  assign chain_ready[ROUND_COUNT] = m_axis_tready;
  assign m_axis_tvalid            = chain_valid[ROUND_COUNT];
  assign m_axis_tdata             = BLOCK_W'(chain_blk[ROUND_COUNT]);

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // input back-pressure only with a full row and a stalled output
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&stage_valid && !m_axis_tready))
    else $error("input stalled while a cell is free");

  // an accepted request lands in the first cell
  a_first_cell_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> stage_valid[0])
    else $error("accepted request lost at first cell");

  // occupancy tracks requests in minus blocks out
  a_occ_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !out_acc) |=>
      ($countones(stage_valid) == $past($countones(stage_valid)) + 1))
    else $error("occupancy did not grow on accept");

  a_occ_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_acc && out_acc) |=>
      ($countones(stage_valid) == $past($countones(stage_valid)) - 1))
    else $error("occupancy did not shrink on delivery");

endmodule : philox_block_generator_core

`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream-level testbench for philox_block_generator_core
// Drives 128-bit counter requests, computes the Philox4x32 block for each
// one under the current key, and checks every output block word by word.
// Keys go through reset values, extremes and random settings over APB,
// with random source gaps and sink stalls, then a final full-rate stretch.
// ----------------------------------------------------------------------------

module tb_top;
  import pbg_pkg::*;

  localparam int unsigned ROUNDS       = ROUND_COUNT_DEF;
  // Pipeline depth plus margin: used after the last expected block.
  localparam int unsigned DRAIN_CYCLES = ROUNDS + 8;
  // Roughly 1700 requests, each at worst a source gap plus a sink stall,
  // plus key writes and drains; taken many times over.
  localparam int unsigned RUN_LIMIT    = 400000;

  // --------------------------------------------------------------------------
  // DUT signals, inputs all known from time zero
  // --------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // fields from bit 0: count_word0, count_word1, count_word2, count_word3
  logic [BLOCK_W-1:0]    s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // fields from bit 0: rand_word0, rand_word1, rand_word2, rand_word3
  logic [BLOCK_W-1:0]    m_axis_tdata;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  philox_block_generator_core #(
    .ROUND_COUNT (ROUNDS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // --------------------------------------------------------------------------
  // Testbench state
  // --------------------------------------------------------------------------
  pbg_key_t    cur_key;           // key as the DUT should hold it
  pbg_block_t  expected_blocks[$]; // one block per accepted request, in order
  pbg_block_t  want_block;
  pbg_block_t  got_block;
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  bit          src_idle_en  = 1'b0;
  bit          sink_idle_en = 1'b0;

  // Clock: 20 time-unit period
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Philox4x32 block computation
  // Each round: two 32x32->64 products; the high halves are folded into the
  // opposite counter words with the round key, the low halves pass through.
  // --------------------------------------------------------------------------
  function automatic pbg_block_t philox_block(input pbg_block_t ctr, input pbg_key_t key);
    pbg_block_t  w;
    pbg_word_t   k0;
    pbg_word_t   k1;
    logic [63:0] prod_a;
    logic [63:0] prod_b;
    w  = ctr;
    k0 = key.k0;
    k1 = key.k1;
    for (int r = 0; r < ROUNDS; r++) begin
      prod_a = 64'(w[0]) * 64'(MUL_A);
      prod_b = 64'(w[2]) * 64'(MUL_B);
      // word order, high to low: w3 = lo(a), w2 = hi(a)^w3^k1,
      //                          w1 = lo(b), w0 = hi(b)^w1^k0
      w = {prod_a[31:0], prod_a[63:32] ^ w[3] ^ k1,
           prod_b[31:0], prod_b[63:32] ^ w[1] ^ k0};
      k0 = k0 + WEYL_A;
      k1 = k1 + WEYL_B;
    end
    return w;
  endfunction

  // Random word biased toward the two extremes
  function automatic pbg_word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return pbg_word_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("tb_top: mismatch: %s", what);
  endtask

  // --------------------------------------------------------------------------
  // Run limit
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sink: tready with random stall bursts
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 8);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Output check: every accepted block against the oldest expected block
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_block = pbg_block_t'(m_axis_tdata);
      if (expected_blocks.size() == 0) begin
        report_mismatch($sformatf("block %h with no request pending", got_block));
      end else begin
        want_block = expected_blocks.pop_front();
        for (int i = 0; i < BLOCK_WORDS; i++) begin
          if (got_block[i] !== want_block[i]) begin
            report_mismatch($sformatf("rand_word%0d got %h want %h",
                                      i, got_block[i], want_block[i]));
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driver
  // Valid stays high from one request to the next unless a gap is drawn, so
  // tvalid gets one assignment per clock step.
  // --------------------------------------------------------------------------
  task automatic send_counter(input pbg_block_t ctr);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ctr;
    do @(posedge clk_i); while (!s_axis_tready);
    // Keys only change with the pipeline empty, so cur_key is the one used.
    expected_blocks.push_back(philox_block(ctr, cur_key));
  endtask

  // Stop requests and let every expected block come out, then let the
  // pipeline settle so a stray extra block would still be caught.
  task automatic drain_blocks();
    s_axis_tvalid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // APB access: setup cycle, then access cycle until pready, then an idle
  // cycle so back-to-back accesses never drive the bus twice in one step
  // --------------------------------------------------------------------------
  task automatic apb_access(input pbg_reg_e sel, input bit wr, input pbg_word_t wdata,
                            output pbg_word_t rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_keys();
    pbg_word_t rd;
    apb_access(REG_KEY_LOW, 1'b0, '0, rd);
    if (rd !== cur_key.k0) report_mismatch($sformatf("key_low read %h want %h", rd, cur_key.k0));
    apb_access(REG_KEY_HIGH, 1'b0, '0, rd);
    if (rd !== cur_key.k1) report_mismatch($sformatf("key_high read %h want %h", rd, cur_key.k1));
  endtask

  // Drains the pipeline before writing the keys.
  task automatic set_keys(input pbg_word_t k0, input pbg_word_t k1);
    pbg_word_t rd;
    drain_blocks();
    apb_access(REG_KEY_LOW, 1'b1, k0, rd);
    cur_key.k0 = k0;
    apb_access(REG_KEY_HIGH, 1'b1, k1, rd);
    cur_key.k1 = k1;
    check_keys();
  endtask

  // Well-formed use: a counter run incrementing with carry across words.
  task automatic send_stream(input int unsigned count);
    logic [BLOCK_W-1:0] ctr;
    case ($urandom_range(0, 2))
      0: ctr = '0;
      1: ctr = {pick_word(), pick_word(), pick_word(), pick_word()};
      default: begin
        // low word just below wrap, upper words biased toward 0 and all ones
        ctr = {pick_word(), pick_word(), pick_word(),
               32'hFFFF_FFFF - pbg_word_t'($urandom_range(0, 40))};
      end
    endcase
    repeat (count) begin
      send_counter(pbg_block_t'(ctr));
      ctr = ctr + 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_values();
    cur_key.k0 = KEY_LOW_RESET;
    cur_key.k1 = KEY_HIGH_RESET;
    check_keys();
  endtask

  // Field extremes and carry boundaries under the reset key.
  task automatic test_corner_counters();
    pbg_block_t corners[14];
    corners = '{
      128'h00000000_00000000_00000000_00000000,
      128'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF,
      128'h00000000_00000000_00000000_FFFFFFFF,
      128'h00000000_00000000_00000001_00000000,
      128'h00000000_00000000_FFFFFFFF_00000000,
      128'h00000000_FFFFFFFF_00000000_00000000,
      128'hFFFFFFFF_00000000_00000000_00000000,
      128'h00000000_FFFFFFFF_FFFFFFFF_FFFFFFFF,
      128'h00000001_00000000_00000000_00000000,
      128'h00000000_00000000_00000000_00000001,
      128'h80000000_80000000_80000000_80000000,
      128'hAAAAAAAA_55555555_AAAAAAAA_55555555,
      128'h55555555_AAAAAAAA_55555555_AAAAAAAA,
      128'h00000001_00000001_00000001_00000001
    };
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    foreach (corners[i]) send_counter(corners[i]);
  endtask

  // Key extremes, two requests each.
  task automatic test_key_extremes();
    pbg_word_t lows[4]  = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    pbg_word_t highs[4] = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0};
    for (int i = 0; i < 4; i++) begin
      set_keys(lows[i], highs[i]);
      send_counter('0);
      send_counter('1);
    end
  endtask

  // Counter runs as a producer would issue them, under several keys.
  task automatic test_counter_streams();
    for (int p = 0; p < 6; p++) begin
      set_keys(pick_word(), pick_word());
      src_idle_en  = $urandom_range(0, 3) != 0;
      sink_idle_en = $urandom_range(0, 3) != 0;
      repeat (4) send_stream($urandom_range(10, 50));
    end
  endtask

  // Arbitrary counters in any order.
  task automatic test_random_counters();
    for (int p = 0; p < 4; p++) begin
      set_keys(pick_word(), pick_word());
      src_idle_en  = $urandom_range(0, 3) != 0;
      sink_idle_en = $urandom_range(0, 3) != 0;
      repeat (150) send_counter({pick_word(), pick_word(), pick_word(), pick_word()});
    end
  endtask

  // Back-to-back requests with the sink always ready: one block per cycle.
  task automatic test_full_rate();
    set_keys(pick_word(), pick_word());
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (3) send_stream(100);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_corner_counters();
    test_key_extremes();
    test_counter_streams();
    test_random_counters();
    test_full_rate();
    drain_blocks();

    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/pbg_pkg.sv
rtl/core/pbg_cfg_regs.sv
rtl/core/pbg_round_cell.sv
rtl/core/philox_block_generator_core.sv
test/tb_top.sv
